[sv/vgrt_pkg.sv]
// Shared types and constants for the voxel grid ray traversal block.
`default_nettype none
package vgrt_pkg;
    localparam int GRID_SIDE_DEF = 16;
    localparam int MAX_STEPS_DEF = 128;
    localparam logic [7:0] EMPTY_CELL = 8'hFF;
    localparam int FRAC_BITS = 12;
    localparam int RECIP_BITS = 31;
    localparam int RATIO_W = 45;
    localparam logic [RATIO_W-1:0] RATIO_FAR = {1'b1, {(RATIO_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECIP,
        ST_INIT,
        ST_READ,
        ST_CHECK,
        ST_DEPTH,
        ST_MUL,
        ST_POINT,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

[sv/vgrt_recip.sv]
// Bit-serial reciprocal unit: floor(2^30 / mag), one quotient bit per cycle.
`default_nettype none
module vgrt_recip
    import vgrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [15:0]           mag,
    output logic                       done,
    output logic [RECIP_BITS-1:0]      quot
);
    logic                  run_reg;
    logic [4:0]            cnt_reg;
    logic [15:0]           rem_reg;
    logic [RECIP_BITS-1:0] quot_reg;
    logic                  done_reg;
    logic [16:0]           rem_sh;
    logic                  ge;
    logic [16:0]           rem_next;

    assign rem_sh   = {rem_reg, cnt_reg == 5'(RECIP_BITS - 1)};
    assign ge       = rem_sh >= {1'b0, mag};
    assign rem_next = ge ? rem_sh - {1'b0, mag} : rem_sh;
    assign done     = done_reg;
    assign quot     = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(RECIP_BITS - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next[15:0];
            quot_reg <= {quot_reg[RECIP_BITS-2:0], ge};
        end
    end
endmodule
`default_nettype wire

[sv/vgrt_store.sv]
// Voxel memory with one write port, one registered read port and a clearing pass.
`default_nettype none
module vgrt_store
    import vgrt_pkg::*;
#(
    parameter int AW = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data,
    output logic               clearing
);
    logic [7:0]    mem [2**AW];
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [7:0]    rd_data_reg;

    assign clearing = clr_reg;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {AW{1'b1}})
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= EMPTY_CELL;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[sv/voxel_grid_ray_traversal.sv]
// Top level: voxel ray caster, 3D DDA over the voxel memory.
//  channel | direction | handshake           | payload
//  input   | in        | in_valid/in_stall   | kind, voxel_*, origin_*, dir_*
//  result  | out       | out_valid/out_stall | hit, hit_value, hit_point_*, hit_depth, hit_face
// Write item: no result. Ray item: reciprocal (31 quotient bits, then done), setup,
// a memory read and a check per cell examined, depth, multiply and point on a hit past the start
// cell, then output; at most MAX_STEPS cells are examined.
// After reset a clearing pass over all 2^(3*clog2(GRID_SIDE)) cells (4096 by default) holds in_stall.
// A result waiting on out_stall holds the ray engine; input is taken once the engine is free.
`default_nettype none
module voxel_grid_ray_traversal
    import vgrt_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [3:0]         voxel_x,
    input  wire logic [3:0]         voxel_y,
    input  wire logic [3:0]         voxel_z,
    input  wire logic [7:0]         voxel_value,
    input  wire logic signed [23:0] origin_x,
    input  wire logic signed [23:0] origin_y,
    input  wire logic signed [23:0] origin_z,
    input  wire logic signed [15:0] dir_x,
    input  wire logic signed [15:0] dir_y,
    input  wire logic signed [15:0] dir_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic [7:0]              hit_value,
    output logic signed [23:0]      hit_point_x,
    output logic signed [23:0]      hit_point_y,
    output logic signed [23:0]      hit_point_z,
    output logic [31:0]             hit_depth,
    output logic [2:0]              hit_face
);
    localparam int CW  = $clog2(GRID_SIDE);
    localparam int AW  = 3 * CW;
    localparam int SCW = $clog2(MAX_STEPS + 1);

    state_t state_reg, state_next;

    logic signed [23:0]    org_in [3];
    logic signed [15:0]    dir_in [3];
    logic signed [23:0]    org_reg [3];
    logic [15:0]           mag_reg [3];
    logic                  neg_reg [3];
    logic [RECIP_BITS-1:0] rstep_reg [3];
    logic [RATIO_W-1:0]    ratio_reg [3];
    logic signed [23:0]    cell_reg [3];
    logic [47:0]           prod_reg [3];
    logic signed [23:0]    point_reg [3];
    logic [RECIP_BITS-1:0] quot [3];
    logic                  rdone [3];
    logic [15:0]           mag_in [3];
    logic [16:0]           neg_ext [3];
    logic                  in_rng [3];
    logic [2:0]            mask_reg;
    logic [2:0]            mask_now;
    logic [2:0]            cmp;
    logic [SCW-1:0]        step_cnt_reg;
    logic                  res_hit_reg;
    logic [7:0]            res_value_reg;
    logic [31:0]           depth_reg;
    logic [2:0]            face_reg;
    logic [1:0]            axis;
    logic [RATIO_W-1:0]    dsub;

    logic out_valid_reg, hit_reg;
    logic [7:0]         hit_value_reg;
    logic signed [23:0] hit_point_reg [3];
    logic [31:0]        hit_depth_reg;
    logic [2:0]         hit_face_reg;

    logic          accept, recip_start, rd_en, wr_en, clearing, occupied, emit;
    logic [31:0]   wx, wy, wz;
    logic          wr_in_rng;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    assign accept = in_valid && !in_stall;
    assign emit   = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign wx = 32'(voxel_x);
    assign wy = 32'(voxel_y);
    assign wz = 32'(voxel_z);
    assign wr_in_rng = (wx < 32'(GRID_SIDE)) && (wy < 32'(GRID_SIDE)) && (wz < 32'(GRID_SIDE));
    assign wr_addr = {wz[CW-1:0], wy[CW-1:0], wx[CW-1:0]};

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign neg_ext[a] = 17'd0 - {dir_in[a][15], dir_in[a]};
        assign mag_in[a]  = dir_in[a][15] ? neg_ext[a][15:0] : dir_in[a];
        assign in_rng[a]  = (cell_reg[a] >= 24'sd0) && (cell_reg[a] < $signed(24'(GRID_SIDE)));

        vgrt_recip u_recip
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (recip_start),
            .mag   (mag_reg[a]),
            .done  (rdone[a]),
            .quot  (quot[a])
        );
    end

    assign rd_addr = {cell_reg[2][CW-1:0], cell_reg[1][CW-1:0], cell_reg[0][CW-1:0]};

    vgrt_store #(.AW(AW)) u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (voxel_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    assign cmp[0]   = ratio_reg[1] >= ratio_reg[0];
    assign cmp[1]   = ratio_reg[2] >= ratio_reg[1];
    assign cmp[2]   = ratio_reg[0] >= ratio_reg[2];
    assign mask_now = {cmp[2] & ~cmp[1], cmp[1] & ~cmp[0], cmp[0] & ~cmp[2]};
    assign occupied = in_rng[0] && in_rng[1] && in_rng[2] && (rd_data != EMPTY_CELL);
    assign axis     = mask_reg[0] ? 2'd0 : (mask_reg[1] ? 2'd1 : 2'd2);
    assign dsub     = ratio_reg[axis] - RATIO_W'(rstep_reg[axis]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind)
                begin
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                if (rdone[0])
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (occupied)
                begin
                    state_next = (step_cnt_reg == '0) ? ST_EMIT : ST_DEPTH;
                end
                else if (step_cnt_reg == SCW'(MAX_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DEPTH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_POINT;
            ST_POINT: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = clearing || (state_reg != ST_IDLE);
        recip_start = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                recip_start = accept && kind;
                wr_en       = accept && !kind && wr_in_rng;
            end
            ST_READ:  rd_en = 1'b1;
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    org_reg[a] <= org_in[a];
                    mag_reg[a] <= mag_in[a];
                    neg_reg[a] <= dir_in[a][15];
                end
            end
            ST_INIT:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    logic [12:0] bound;
                    logic [43:0] prod;
                    bound = neg_reg[a] ? {1'b0, org_reg[a][11:0]}
                                       : 13'd4096 - {1'b0, org_reg[a][11:0]};
                    prod = 44'(bound) * 44'(quot[a]);
                    cell_reg[a] <= org_reg[a] >>> FRAC_BITS;
                    if (mag_reg[a] == 16'd0)
                    begin
                        rstep_reg[a] <= '0;
                        ratio_reg[a] <= RATIO_FAR;
                    end
                    else
                    begin
                        rstep_reg[a] <= quot[a];
                        ratio_reg[a] <= RATIO_W'(prod >> FRAC_BITS);
                    end
                end
                step_cnt_reg <= '0;
                mask_reg     <= '0;
                res_hit_reg  <= 1'b0;
            end
            ST_CHECK:
            begin
                if (occupied)
                begin
                    res_hit_reg   <= (step_cnt_reg != '0);
                    res_value_reg <= rd_data;
                end
                else
                begin
                    mask_reg     <= mask_now;
                    step_cnt_reg <= step_cnt_reg + 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        if (mask_now[a])
                        begin
                            cell_reg[a]  <= neg_reg[a] ? cell_reg[a] - 24'sd1
                                                       : cell_reg[a] + 24'sd1;
                            ratio_reg[a] <= ratio_reg[a] + RATIO_W'(rstep_reg[a]);
                        end
                    end
                end
            end
            ST_DEPTH:
            begin
                depth_reg <= (dsub[RATIO_W-1:32] != '0) ? 32'hFFFF_FFFF : dsub[31:0];
                face_reg  <= {axis, neg_reg[axis]};
            end
            ST_MUL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    prod_reg[a] <= 48'(depth_reg) * 48'(mag_reg[a]);
                end
            end
            ST_POINT:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    logic signed [31:0] off;
                    logic signed [31:0] p;
                    off = $signed({2'b00, prod_reg[a][47:18]});
                    p   = neg_reg[a] ? 32'(org_reg[a]) - off : 32'(org_reg[a]) + off;
                    if (p > 32'sd8388607)
                    begin
                        point_reg[a] <= 24'sh7FFFFF;
                    end
                    else if (p < -32'sd8388608)
                    begin
                        point_reg[a] <= 24'sh800000;
                    end
                    else
                    begin
                        point_reg[a] <= p[23:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            hit_reg       <= res_hit_reg;
            hit_value_reg <= res_hit_reg ? res_value_reg : EMPTY_CELL;
            hit_depth_reg <= res_hit_reg ? depth_reg : 32'd0;
            hit_face_reg  <= res_hit_reg ? face_reg : 3'd0;
            for (int a = 0; a < 3; a++)
            begin
                hit_point_reg[a] <= res_hit_reg ? point_reg[a] : 24'sd0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign hit_value   = hit_value_reg;
    assign hit_point_x = hit_point_reg[0];
    assign hit_point_y = hit_point_reg[1];
    assign hit_point_z = hit_point_reg[2];
    assign hit_depth   = hit_depth_reg;
    assign hit_face    = hit_face_reg;
endmodule
`default_nettype wire
